@@ rtl/aes_ctr_pkg.sv @@
// shared types, constants and functions for the aes-128 ctr byte cipher
`timescale 1ns / 1ps
package aes_ctr_pkg;

	typedef enum logic [1:0] {
		REG_KEY_HIGH = 2'd0,
		REG_KEY_LOW  = 2'd1,
		REG_IV_HIGH  = 2'd2,
		REG_IV_LOW   = 2'd3
	} reg_idx_t;

	localparam int NUM_ROUNDS = 10;

	typedef struct packed {
		logic         start;
		logic [127:0] block;
	} core_req_t;

	typedef struct packed {
		logic         busy;
		logic         done;
		logic [127:0] block;
	} core_rsp_t;

	function automatic logic [7:0] sbox(input logic [7:0] a);
		logic [7:0] tbl [0:255];
		tbl = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
		return tbl[a];
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] v);
		return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] rcon(input logic [3:0] r);
		logic [7:0] v;
		case (r)
			4'd1:    v = 8'h01;
			4'd2:    v = 8'h02;
			4'd3:    v = 8'h04;
			4'd4:    v = 8'h08;
			4'd5:    v = 8'h10;
			4'd6:    v = 8'h20;
			4'd7:    v = 8'h40;
			4'd8:    v = 8'h80;
			4'd9:    v = 8'h1b;
			4'd10:   v = 8'h36;
			default: v = 8'h00;
		endcase
		return v;
	endfunction

endpackage

@@ rtl/aes_ctr_core.sv @@
// iterative aes-128 encryption: one round and one round-key step per cycle
`timescale 1ns / 1ps
module aes_ctr_core
	import aes_ctr_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic [127:0] key,
	input  core_req_t    req,
	output core_rsp_t    rsp
);

	logic [127:0] state_q;
	logic [127:0] rk_q;
	logic [3:0]   round_q;
	logic         busy_q;
	logic         done_q;

	logic [127:0] rk_next;
	logic [127:0] sr;
	logic [127:0] mc;
	logic [127:0] rnd_out;
	logic [31:0]  rot;

	// next round key from the current one
	always_comb begin
		logic [31:0] w0, w1, w2, w3, t;
		rot = {rk_q[23:0], rk_q[31:24]};
		t  = {sbox(rot[31:24]) ^ rcon(round_q), sbox(rot[23:16]),
			sbox(rot[15:8]), sbox(rot[7:0])};
		w0 = rk_q[127:96] ^ t;
		w1 = rk_q[95:64] ^ w0;
		w2 = rk_q[63:32] ^ w1;
		w3 = rk_q[31:0] ^ w2;
		rk_next = {w0, w1, w2, w3};
	end

	// sub bytes with shift rows, then mix columns
	always_comb begin
		logic [7:0] a, b, c, d, e;
		for (int i = 0; i < 16; i++) begin
			sr[127 - 8*i -: 8] = sbox(state_q[127 - 8*((((i >> 2) + (i & 3)) & 3) * 4
				+ (i & 3)) -: 8]);
		end
		for (int k = 0; k < 4; k++) begin
			a = sr[127 - 32*k -: 8];
			b = sr[119 - 32*k -: 8];
			c = sr[111 - 32*k -: 8];
			d = sr[103 - 32*k -: 8];
			e = a ^ b ^ c ^ d;
			mc[127 - 32*k -: 8] = a ^ e ^ xtime(a ^ b);
			mc[119 - 32*k -: 8] = b ^ e ^ xtime(b ^ c);
			mc[111 - 32*k -: 8] = c ^ e ^ xtime(c ^ d);
			mc[103 - 32*k -: 8] = d ^ e ^ xtime(d ^ a);
		end
		rnd_out = ((round_q == 4'(NUM_ROUNDS)) ? sr : mc) ^ rk_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			round_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q  <= 1'b1;
				round_q <= 4'd1;
			end else if (busy_q) begin
				round_q <= round_q + 4'd1;
				if (round_q == 4'(NUM_ROUNDS)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			state_q <= req.block ^ key;
			rk_q    <= key;
		end else if (busy_q) begin
			state_q <= rnd_out;
			rk_q    <= rk_next;
		end
	end

	assign rsp.busy  = busy_q;
	assign rsp.done  = done_q;
	assign rsp.block = state_q;

endmodule

@@ rtl/aes128_ctr_byte_cipher.sv @@
// top level of the aes-128 counter-mode byte cipher
// a byte that opens a 16-byte group waits for one block encryption; other bytes
// of the group skip it and go straight to the xor with the stored keystream
// one byte is taken at a time; a byte that opens a group goes through load,
// 10 rounds on the shared round unit, capture and xor
// reset: arst_n clears key, iv, counter state and handshakes; keystream undefined
`timescale 1ns / 1ps
module aes128_ctr_byte_cipher
	import aes_ctr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_in,
	input  logic        first_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  data_out,
	output logic        last_out
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_ENC  = 3'b010,
		ST_OUT  = 3'b100
	} state_t;

	state_t        state_q;
	logic [127:0]  key_q;
	logic [127:0]  iv_q;
	logic [127:0]  ctr_q;
	logic [127:0]  ks_q;
	logic [3:0]    pos_q;
	logic          open_q;
	logic [7:0]    data_q;
	logic          last_q;
	logic          out_valid_q;

	core_req_t     creq;
	core_rsp_t     crsp;

	// per-byte view of the counter state at transfer
	logic          restart;
	logic [3:0]    pos_eff;
	logic [127:0]  ctr_eff;
	logic [7:0]    ks_byte;

	aes_ctr_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.key    (key_q),
		.req    (creq),
		.rsp    (crsp)
	);

	assign restart = first_byte || !open_q;
	assign pos_eff = restart ? 4'd0 : pos_q;
	assign ctr_eff = restart ? iv_q : ctr_q;

	// accept while idle and the output register is free or being drained
	assign in_ready = (state_q == ST_IDLE) && (!out_valid_q || out_ready);

	assign creq.start = in_valid && in_ready && (pos_eff == 4'd0);
	assign creq.block = ctr_eff;

	assign ks_byte = ks_q[127 - 8*pos_q -: 8];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
			iv_q  <= '0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_KEY_HIGH: key_q[127:64] <= cfg_data;
				REG_KEY_LOW:  key_q[63:0]   <= cfg_data;
				REG_IV_HIGH:  iv_q[127:64]  <= cfg_data;
				REG_IV_LOW:   iv_q[63:0]    <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ctr_q       <= '0;
			pos_q       <= '0;
			open_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid && in_ready) begin
						open_q <= !last_byte;
						pos_q  <= pos_eff;
						if (pos_eff == 4'd0) begin
							// new group: encrypt counter, then step it
							ctr_q   <= ctr_eff + 128'd1;
							state_q <= ST_ENC;
						end else begin
							ctr_q   <= ctr_eff;
							state_q <= ST_OUT;
						end
					end
				end
				ST_ENC: begin
					if (crsp.done) state_q <= ST_OUT;
				end
				ST_OUT: begin
					out_valid_q <= 1'b1;
					pos_q       <= pos_q + 4'd1;
					state_q     <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_q <= data_in;
			last_q <= last_byte;
		end
		if (state_q == ST_ENC && crsp.done) ks_q <= crsp.block;
		if (state_q == ST_OUT) data_q <= data_q ^ ks_byte;
	end

	assign out_valid = out_valid_q;
	assign data_out  = data_q;
	assign last_out  = last_q;

endmodule

@@ rtl/aes_ctr_checker.sv @@
// port-level checker for the aes-128 ctr byte cipher, bound to the top level
`timescale 1ns / 1ps
module aes_ctr_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [7:0] data_out,
	input logic last_out
);

	// a result stays offered until its transfer
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(data_out) && $stable(last_out))
		else $error("result dropped or changed while stalled");

	// no new byte is taken in the cycle right after one was taken
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("byte accepted while previous one in flight");

	// a byte transfer never gives a result in the cycle right after it
	a_no_early_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result appeared too early");

endmodule

bind aes128_ctr_byte_cipher aes_ctr_checker u_aes_ctr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.data_out  (data_out),
	.last_out  (last_out)
);

@@ verif/aes128_ctr_byte_cipher_test.sv @@
// testbench for the aes-128 counter-mode byte cipher
`timescale 1ns / 1ps
module aes128_ctr_byte_cipher_test;
	import aes_ctr_pkg::*;

	// one expected output byte with its end-of-message flag
	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} cipher_byte_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	reg_idx_t    cfg_index = REG_KEY_HIGH;
	logic [63:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_in = '0;
	logic        first_byte = 1'b0;
	logic        last_byte = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  data_out;
	logic        last_out;

	aes128_ctr_byte_cipher DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.data_in(data_in), .first_byte(first_byte), .last_byte(last_byte),
		.out_valid(out_valid), .out_ready(out_ready),
		.data_out(data_out), .last_out(last_out)
	);

	always #1 clk = ~clk;

	// forward s-box, kept locally so the prediction stands apart from the rtl
	const logic [7:0] fwd_sbox [0:255] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

	const logic [7:0] round_rcon [1:10] = '{
		8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36};

	// predictor state: registers, counter, current keystream, expanded key
	logic [127:0] key_reg, iv_reg, ctr_block, ks_block;
	logic [3:0]   ks_pos;
	logic         in_message;
	logic [31:0]  sched [0:43];

	cipher_byte_t expected_bytes [$];
	int           mismatches = 0;
	int           quiet_cycles = 0;
	bit           idle_on = 1'b1;
	bit           long_hold = 1'b0;

	function automatic logic [7:0] gf_double(input logic [7:0] v);
		return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic void build_schedule();
		logic [31:0] w;
		for (int i = 0; i < 4; i++)
			sched[i] = key_reg[127 - 32 * i -: 32];
		for (int i = 4; i < 44; i++) begin
			w = sched[i - 1];
			if (i % 4 == 0) begin
				w = {w[23:0], w[31:24]};
				w = {fwd_sbox[w[31:24]], fwd_sbox[w[23:16]],
					fwd_sbox[w[15:8]], fwd_sbox[w[7:0]]};
				w[31:24] ^= round_rcon[i / 4];
			end
			sched[i] = sched[i - 4] ^ w;
		end
	endfunction

	function automatic logic [127:0] encrypt_block(input logic [127:0] blk);
		logic [7:0] st [0:15];
		logic [7:0] sh [0:15];
		logic [7:0] a, b, c, d, e;
		logic [127:0] res;
		for (int i = 0; i < 16; i++)
			st[i] = blk[127 - 8 * i -: 8] ^ sched[i / 4][31 - 8 * (i % 4) -: 8];
		for (int rnd = 1; rnd <= 10; rnd++) begin
			// substitution with row rotation: row r of column c comes from column c+r
			for (int i = 0; i < 16; i++)
				sh[i] = fwd_sbox[st[(((i / 4) + (i % 4)) % 4) * 4 + (i % 4)]];
			for (int col = 0; col < 4; col++) begin
				a = sh[4 * col]; b = sh[4 * col + 1]; c = sh[4 * col + 2]; d = sh[4 * col + 3];
				if (rnd < 10) begin
					e = a ^ b ^ c ^ d;
					st[4 * col]     = a ^ e ^ gf_double(a ^ b);
					st[4 * col + 1] = b ^ e ^ gf_double(b ^ c);
					st[4 * col + 2] = c ^ e ^ gf_double(c ^ d);
					st[4 * col + 3] = d ^ e ^ gf_double(d ^ a);
				end else begin
					st[4 * col] = a; st[4 * col + 1] = b; st[4 * col + 2] = c; st[4 * col + 3] = d;
				end
			end
			for (int i = 0; i < 16; i++)
				st[i] ^= sched[rnd * 4 + i / 4][31 - 8 * (i % 4) -: 8];
		end
		for (int i = 0; i < 16; i++)
			res[127 - 8 * i -: 8] = st[i];
		return res;
	endfunction

	// works out the output byte for one accepted input byte
	function automatic cipher_byte_t cipher_step(input logic [7:0] d, input logic f,
		input logic l);
		cipher_byte_t r;
		if (f || !in_message) begin
			ctr_block = iv_reg;
			ks_pos = '0;
			in_message = 1'b1;
		end
		if (ks_pos == 0) begin
			ks_block = encrypt_block(ctr_block);
			ctr_block = ctr_block + 128'd1;
		end
		r.data = d ^ ks_block[127 - 8 * ks_pos -: 8];
		r.last = l;
		ks_pos = ks_pos + 4'd1;
		if (l)
			in_message = 1'b0;
		return r;
	endfunction

	// receiver: random stall bursts, and one long hold-off on request
	always @(posedge clk) begin
		if (arst_n) begin
			if (long_hold) begin
				out_ready <= 1'b0;
				repeat (60) @(posedge clk);
				long_hold = 1'b0;
				out_ready <= 1'b1;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// checks each output transfer against the oldest expectation
	always @(posedge clk) begin
		cipher_byte_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_bytes.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected output byte %h last %b", data_out, last_out);
			end else begin
				want = expected_bytes.pop_front();
				if (data_out !== want.data || last_out !== want.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %h last %b, got %h last %b",
							want.data, want.last, data_out, last_out);
				end
			end
		end
	end

	// watchdog on cycles with no transfer on either side
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 3000) begin
			$display("FAIL");
			$finish;
		end
	end

	// one input transfer, with a random gap ahead of it while idling is on
	task automatic offer_byte(input logic [7:0] d, input logic f, input logic l);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_in <= d;
		first_byte <= f;
		last_byte <= l;
		do @(posedge clk); while (!in_ready);
		expected_bytes.push_back(cipher_step(d, f, l));
	endtask

	// stop sending and wait for every expected byte, then let the block settle
	task automatic drain();
		in_valid <= 1'b0;
		while (expected_bytes.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [63:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_KEY_HIGH: key_reg[127:64] = val;
			REG_KEY_LOW:  key_reg[63:0] = val;
			REG_IV_HIGH:  iv_reg[127:64] = val;
			REG_IV_LOW:   iv_reg[63:0] = val;
			default: ;
		endcase
		build_schedule();
	endtask

	task automatic load_config(input logic [127:0] k, input logic [127:0] iv);
		drain();
		write_reg(REG_KEY_HIGH, k[127:64]);
		write_reg(REG_KEY_LOW, k[63:0]);
		write_reg(REG_IV_HIGH, iv[127:64]);
		write_reg(REG_IV_LOW, iv[63:0]);
		// settling margin after the register writes
		repeat (30) @(posedge clk);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// a message of n bytes with clean first and last marks
	task automatic send_message(input int n);
		for (int i = 0; i < n; i++)
			offer_byte(8'($urandom_range(0, 255)), i == 0, i == n - 1);
	endtask

	// extremes of the byte, one-byte messages, implicit start after last, group wrap
	task automatic test_directed();
		offer_byte(8'h00, 1'b1, 1'b0);
		offer_byte(8'hff, 1'b0, 1'b0);
		offer_byte(8'h55, 1'b0, 1'b1);
		offer_byte(8'haa, 1'b1, 1'b1);
		offer_byte(8'h0f, 1'b0, 1'b0);
		offer_byte(8'hf0, 1'b1, 1'b0);
		for (int i = 0; i < 17; i++)
			offer_byte(i[7:0], 1'b0, i == 16);
	endtask

	// all-ones and all-zero keys, and counters that wrap at the low half and at the top
	task automatic test_extremes();
		load_config({128{1'b1}}, {128{1'b1}});
		send_message(20);
		load_config({128{1'b1}}, {64'h0, {64{1'b1}}});
		send_message(18);
		load_config(128'h0, {{64{1'b1}}, 64'h0});
		send_message(3);
	endtask

	// mostly well-formed messages of random length, some with random marks
	task automatic test_random(input int nbytes);
		int sent;
		int n;
		sent = 0;
		while (sent < nbytes) begin
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(33, 70) : $urandom_range(1, 32);
			if ($urandom_range(0, 6) == 0) begin
				for (int i = 0; i < n; i++)
					offer_byte(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0,
						$urandom_range(0, 5) == 0);
			end else begin
				send_message(n);
			end
			sent += n;
		end
	endtask

	// receiver holds off while the sender keeps offering bytes
	task automatic test_backpressure();
		long_hold = 1'b1;
		send_message(40);
		// sender waits until the output side has caught up
		in_valid <= 1'b0;
		while (expected_bytes.size() != 0) @(posedge clk);
		send_message(10);
	endtask

	initial begin
		key_reg = '0;
		iv_reg = '0;
		ctr_block = '0;
		ks_block = '0;
		ks_pos = '0;
		in_message = 1'b0;
		build_schedule();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_directed();
		test_extremes();
		for (int p = 0; p < 5; p++) begin
			load_config({rand64(), rand64()}, {rand64(), rand64()});
			test_random(150);
		end
		test_backpressure();
		load_config({rand64(), rand64()}, {rand64(), 64'hffff_ffff_ffff_ffd0});
		idle_on = 1'b0;
		test_random(100);

		drain();
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
